>>> rtl/ebca_pkg.sv
// Shared types and constants for the 8-bit CPU ALU with flags.
`default_nettype none

package ebca_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RRCA  = 5'd11,
        OP_RLA   = 5'd12,
        OP_RRA   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CPL   = 5'd15,
        OP_SCF   = 5'd16,
        OP_CCF   = 5'd17,
        OP_RLC   = 5'd18,
        OP_RRC   = 5'd19,
        OP_RL    = 5'd20,
        OP_RR    = 5'd21,
        OP_SLA   = 5'd22,
        OP_SRA   = 5'd23,
        OP_SWAP  = 5'd24,
        OP_SRL   = 5'd25,
        OP_BIT   = 5'd26,
        OP_RES   = 5'd27,
        OP_SET   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } t_op;

    // Decimal adjust corrections and limits
    localparam logic [7:0]  DAA_HI_CORR = 8'h60;
    localparam logic [7:0]  DAA_LO_CORR = 8'h06;
    localparam logic [7:0]  BCD_BYTE_MAX = 8'h99;
    localparam logic [3:0]  BCD_NIB_MAX = 4'h9;
    // Bit mask seed for bit, res and set
    localparam logic [7:0]  BIT_SEED = 8'b0000_0001;
    // Low 12 bits of a 16-bit add (half carry out of bit 11)
    localparam logic [15:0] ADD16_H_MASK = 16'h0FFF;

    // One operation request
    typedef struct packed {
        t_op         op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } t_req;

    // One operation result
    typedef struct packed {
        logic [15:0] result;
        logic        writes_back;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/ebca_req_if.sv
// Request channel interface: valid/ready handshake with the operation payload.
`default_nettype none

interface ebca_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        subtract_in;
    logic        half_in;
    logic        carry_in;

    modport source (
        output valid, op, operand_a, operand_b, bit_index,
               zero_in, subtract_in, half_in, carry_in,
        input  ready
    );

    modport sink (
        input  valid, op, operand_a, operand_b, bit_index,
               zero_in, subtract_in, half_in, carry_in,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ebca_rsp_if.sv
// Result channel interface: valid/ready handshake with the result payload.
`default_nettype none

interface ebca_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic        writes_back;
    logic        zero_out;
    logic        subtract_out;
    logic        half_out;
    logic        carry_out;

    modport source (
        output valid, result, writes_back, zero_out, subtract_out, half_out, carry_out,
        input  ready
    );

    modport sink (
        input  valid, result, writes_back, zero_out, subtract_out, half_out, carry_out,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ebca_core.sv
// Combinational ALU datapath: one operation to result, write-back mark and flags.
`default_nettype none

module ebca_core (
    input  wire ebca_pkg::t_req i_req,
    output ebca_pkg::t_rsp o_rsp
);

    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic        w_cin;
    logic [8:0]  w_add9;
    logic [4:0]  w_addh;
    logic [8:0]  w_sub9;
    logic [4:0]  w_subh;
    logic [7:0]  w_mask;
    logic [7:0]  w_inc;
    logic [7:0]  w_dec;
    logic [16:0] w_add17;
    logic [12:0] w_add16h;
    logic [15:0] w_spext;
    logic [4:0]  w_sph;
    logic [8:0]  w_spc;
    logic        w_daa_hi;
    logic        w_daa_lo;
    logic [7:0]  w_daa;

    assign w_a = i_req.operand_a[7:0];
    assign w_b = i_req.operand_b[7:0];

    // Carry in only for adc and sbc
    assign w_cin = ((i_req.op == ebca_pkg::OP_ADC) || (i_req.op == ebca_pkg::OP_SBC))
                   ? i_req.carry_in : 1'b0;

    // 8-bit add and subtract with half carries
    assign w_add9 = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_cin};
    assign w_addh = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_cin};
    assign w_sub9 = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_cin};
    assign w_subh = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_cin};

    assign w_inc  = w_a + 8'd1;
    assign w_dec  = w_a - 8'd1;
    assign w_mask = ebca_pkg::BIT_SEED << i_req.bit_index;

    // 16-bit add, half carry out of bit 11
    assign w_add17  = {1'b0, i_req.operand_a} + {1'b0, i_req.operand_b};
    assign w_add16h = {1'b0, i_req.operand_a[11:0] & ebca_pkg::ADD16_H_MASK[11:0]}
                    + {1'b0, i_req.operand_b[11:0] & ebca_pkg::ADD16_H_MASK[11:0]};

    // sp plus signed byte; flags from the unsigned low-byte sum
    assign w_spext = i_req.operand_a + {{8{w_b[7]}}, w_b};
    assign w_sph   = {1'b0, i_req.operand_a[3:0]} + {1'b0, w_b[3:0]};
    assign w_spc   = {1'b0, i_req.operand_a[7:0]} + {1'b0, w_b};

    // Decimal adjust: high test on the original value
    assign w_daa_hi = i_req.carry_in || (w_a > ebca_pkg::BCD_BYTE_MAX);
    assign w_daa_lo = i_req.half_in || (w_a[3:0] > ebca_pkg::BCD_NIB_MAX);

    always_comb begin
        logic [7:0] v_r;
        v_r = w_a;
        if (!i_req.subtract_in) begin
            if (w_daa_hi) begin
                v_r = v_r + ebca_pkg::DAA_HI_CORR;
            end
            if (w_daa_lo) begin
                v_r = v_r + ebca_pkg::DAA_LO_CORR;
            end
        end else begin
            if (i_req.carry_in) begin
                v_r = v_r - ebca_pkg::DAA_HI_CORR;
            end
            if (i_req.half_in) begin
                v_r = v_r - ebca_pkg::DAA_LO_CORR;
            end
        end
        w_daa = v_r;
    end

    // Operation select
    always_comb begin
        logic [7:0] v_r;
        logic       v_c;
        v_r = w_a;
        v_c = i_req.carry_in;
        o_rsp.result       = {8'd0, w_a};
        o_rsp.writes_back  = 1'b1;
        o_rsp.zero_out     = i_req.zero_in;
        o_rsp.subtract_out = i_req.subtract_in;
        o_rsp.half_out     = i_req.half_in;
        o_rsp.carry_out    = i_req.carry_in;
        case (i_req.op)
            ebca_pkg::OP_ADD, ebca_pkg::OP_ADC: begin
                o_rsp.result       = {8'd0, w_add9[7:0]};
                o_rsp.zero_out     = (w_add9[7:0] == 8'd0);
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = w_addh[4];
                o_rsp.carry_out    = w_add9[8];
            end
            ebca_pkg::OP_SUB, ebca_pkg::OP_SBC, ebca_pkg::OP_CP: begin
                if (i_req.op != ebca_pkg::OP_CP) begin
                    o_rsp.result = {8'd0, w_sub9[7:0]};
                end
                o_rsp.writes_back  = (i_req.op != ebca_pkg::OP_CP);
                o_rsp.zero_out     = (w_sub9[7:0] == 8'd0);
                o_rsp.subtract_out = 1'b1;
                o_rsp.half_out     = w_subh[4];
                o_rsp.carry_out    = w_sub9[8];
            end
            ebca_pkg::OP_AND, ebca_pkg::OP_XOR, ebca_pkg::OP_OR: begin
                if (i_req.op == ebca_pkg::OP_AND) begin
                    v_r = w_a & w_b;
                end else if (i_req.op == ebca_pkg::OP_XOR) begin
                    v_r = w_a ^ w_b;
                end else begin
                    v_r = w_a | w_b;
                end
                o_rsp.result       = {8'd0, v_r};
                o_rsp.zero_out     = (v_r == 8'd0);
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = (i_req.op == ebca_pkg::OP_AND);
                o_rsp.carry_out    = 1'b0;
            end
            ebca_pkg::OP_INC: begin
                o_rsp.result       = {8'd0, w_inc};
                o_rsp.zero_out     = (w_inc == 8'd0);
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = (w_a[3:0] == 4'hF);
            end
            ebca_pkg::OP_DEC: begin
                o_rsp.result       = {8'd0, w_dec};
                o_rsp.zero_out     = (w_dec == 8'd0);
                o_rsp.subtract_out = 1'b1;
                o_rsp.half_out     = (w_a[3:0] == 4'h0);
            end
            ebca_pkg::OP_RLCA, ebca_pkg::OP_RRCA, ebca_pkg::OP_RLA, ebca_pkg::OP_RRA,
            ebca_pkg::OP_RLC, ebca_pkg::OP_RRC, ebca_pkg::OP_RL, ebca_pkg::OP_RR,
            ebca_pkg::OP_SLA, ebca_pkg::OP_SRA, ebca_pkg::OP_SWAP, ebca_pkg::OP_SRL: begin
                // Rotates and shifts; accumulator forms clear Z
                if ((i_req.op == ebca_pkg::OP_RLCA) || (i_req.op == ebca_pkg::OP_RLC)) begin
                    v_r = {w_a[6:0], w_a[7]};
                    v_c = w_a[7];
                end else if ((i_req.op == ebca_pkg::OP_RRCA) ||
                             (i_req.op == ebca_pkg::OP_RRC)) begin
                    v_r = {w_a[0], w_a[7:1]};
                    v_c = w_a[0];
                end else if ((i_req.op == ebca_pkg::OP_RLA) ||
                             (i_req.op == ebca_pkg::OP_RL)) begin
                    v_r = {w_a[6:0], i_req.carry_in};
                    v_c = w_a[7];
                end else if ((i_req.op == ebca_pkg::OP_RRA) ||
                             (i_req.op == ebca_pkg::OP_RR)) begin
                    v_r = {i_req.carry_in, w_a[7:1]};
                    v_c = w_a[0];
                end else if (i_req.op == ebca_pkg::OP_SLA) begin
                    v_r = {w_a[6:0], 1'b0};
                    v_c = w_a[7];
                end else if (i_req.op == ebca_pkg::OP_SRA) begin
                    v_r = {w_a[7], w_a[7:1]};
                    v_c = w_a[0];
                end else if (i_req.op == ebca_pkg::OP_SWAP) begin
                    v_r = {w_a[3:0], w_a[7:4]};
                    v_c = 1'b0;
                end else begin
                    v_r = {1'b0, w_a[7:1]};
                    v_c = w_a[0];
                end
                o_rsp.result       = {8'd0, v_r};
                o_rsp.zero_out     = (i_req.op >= ebca_pkg::OP_RLC) ? (v_r == 8'd0) : 1'b0;
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = 1'b0;
                o_rsp.carry_out    = v_c;
            end
            ebca_pkg::OP_DAA: begin
                o_rsp.result    = {8'd0, w_daa};
                o_rsp.zero_out  = (w_daa == 8'd0);
                o_rsp.half_out  = 1'b0;
                o_rsp.carry_out = i_req.subtract_in ? i_req.carry_in
                                                    : (i_req.carry_in || w_daa_hi);
            end
            ebca_pkg::OP_CPL: begin
                o_rsp.result       = {8'd0, ~w_a};
                o_rsp.subtract_out = 1'b1;
                o_rsp.half_out     = 1'b1;
            end
            ebca_pkg::OP_SCF, ebca_pkg::OP_CCF: begin
                o_rsp.writes_back  = 1'b0;
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = 1'b0;
                o_rsp.carry_out    = (i_req.op == ebca_pkg::OP_SCF) ? 1'b1 : ~i_req.carry_in;
            end
            ebca_pkg::OP_BIT: begin
                o_rsp.writes_back  = 1'b0;
                o_rsp.zero_out     = ((w_a & w_mask) == 8'd0);
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = 1'b1;
            end
            ebca_pkg::OP_RES: begin
                o_rsp.result = {8'd0, w_a & ~w_mask};
            end
            ebca_pkg::OP_SET: begin
                o_rsp.result = {8'd0, w_a | w_mask};
            end
            ebca_pkg::OP_ADD16: begin
                o_rsp.result       = w_add17[15:0];
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = w_add16h[12];
                o_rsp.carry_out    = w_add17[16];
            end
            ebca_pkg::OP_ADDSP: begin
                o_rsp.result       = w_spext;
                o_rsp.zero_out     = 1'b0;
                o_rsp.subtract_out = 1'b0;
                o_rsp.half_out     = w_sph[4];
                o_rsp.carry_out    = w_spc[8];
            end
            default: begin
                // Unused code: operand_a passes, nothing stored, flags kept
                o_rsp.result      = i_req.operand_a;
                o_rsp.writes_back = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/eight_bit_cpu_alu_with_flags.sv
// Top level of the 8-bit CPU ALU with flags: input register, datapath, result register.
//
// Usage:
//   i_req is the request channel (valid/ready): operation code, two 16-bit
//   operands, a bit index and the current Z/N/H/C flags. o_rsp is the result
//   channel (valid/ready): result, write-back mark and the new flags.
//   Every accepted request transaction yields exactly one result transaction,
//   in order.
// Path: a request passes the input register, then the result register, before
//   o_rsp.valid rises; a stall at the result register can hold it in between.
// Throughput: one transaction per cycle, sustained while o_rsp.ready stays high;
//   the whole operation is one pass through the datapath between the two registers.
// Stalls: when the receiver holds ready low, the result register holds its
//   transaction and the input register fills behind it; i_req.ready falls
//   only once both are full, and no transaction is dropped or repeated.
// Reset: synchronous, active low; clears both valid bits, so the block comes
//   up empty and ready.
`default_nettype none

module eight_bit_cpu_alu_with_flags (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ebca_req_if.sink   i_req,
    ebca_rsp_if.source o_rsp
);

    logic             r_req_valid;
    logic             n_req_valid;
    ebca_pkg::t_req   r_req;
    logic             r_rsp_valid;
    logic             n_rsp_valid;
    ebca_pkg::t_rsp   r_rsp;
    ebca_pkg::t_rsp   w_rsp;
    logic             w_adv;
    logic             w_take;

    // Stage advance: result register empty or being drained
    assign w_adv       = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = !r_req_valid || w_adv;
    assign w_take      = i_req.valid && i_req.ready;

    assign n_req_valid = w_take || (r_req_valid && !w_adv);
    assign n_rsp_valid = w_adv ? r_req_valid : r_rsp_valid;

    // Datapath
    ebca_core u_core (
        .i_req (r_req),
        .o_rsp (w_rsp)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req.op          <= ebca_pkg::t_op'(i_req.op);
            r_req.operand_a   <= i_req.operand_a;
            r_req.operand_b   <= i_req.operand_b;
            r_req.bit_index   <= i_req.bit_index;
            r_req.zero_in     <= i_req.zero_in;
            r_req.subtract_in <= i_req.subtract_in;
            r_req.half_in     <= i_req.half_in;
            r_req.carry_in    <= i_req.carry_in;
        end
        if (w_adv && r_req_valid) begin
            r_rsp <= w_rsp;
        end
    end

    // Result channel
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.result       = r_rsp.result;
    assign o_rsp.writes_back  = r_rsp.writes_back;
    assign o_rsp.zero_out     = r_rsp.zero_out;
    assign o_rsp.subtract_out = r_rsp.subtract_out;
    assign o_rsp.half_out     = r_rsp.half_out;
    assign o_rsp.carry_out    = r_rsp.carry_out;

    // A held request moves into the result register on advance
    a_req_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid && w_adv |=> r_rsp_valid)
        else $error("request in input register was lost");

    // A stalled result is never overwritten
    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && !o_rsp.ready |=> r_rsp_valid && $stable(r_rsp))
        else $error("stalled result changed");

    // Compare and flag-only operations never store a result
    a_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid && w_adv &&
        (r_req.op == ebca_pkg::OP_CP || r_req.op == ebca_pkg::OP_BIT ||
         r_req.op == ebca_pkg::OP_SCF || r_req.op == ebca_pkg::OP_CCF)
        |=> !r_rsp.writes_back)
        else $error("non-storing operation marked for write-back");

    // Input stays blocked only while both registers are full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_req_valid && r_rsp_valid)
        else $error("request blocked with a free register");

endmodule

`default_nettype wire
